// File: rtl/core/cbt_pkg.sv
// Shared types, constants and helpers for the cylindrical billboard transform.
package cbt_pkg;

	localparam int ONE_Q14 = 16384;

	localparam int SQ_N   = 30;
	localparam int RAD_W  = 2 * SQ_N;
	localparam int ROOT_W = SQ_N;
	localparam int REM_W  = SQ_N + 3;

	localparam int DV_N = 15;
	localparam int Q_W  = DV_N;
	localparam int DV_W = 46;

	localparam int LANES  = 5;
	localparam int LN_COS = 0;
	localparam int LN_SIN = 1;
	localparam int LN_UX  = 2;

	localparam int CH_N = SQ_N + 1 + DV_N;

	typedef enum logic [2:0] {
		CFG_AXIS_X  = 3'd0,
		CFG_AXIS_Y  = 3'd1,
		CFG_AXIS_Z  = 3'd2,
		CFG_SCALE_X = 3'd3,
		CFG_SCALE_Y = 3'd4,
		CFG_SCALE_Z = 3'd5
	} cbt_cfg_idx_t;

	typedef logic [2:0][31:0] cbt_vec3_t;

	typedef struct packed {
		logic                        valid;
		logic                        rzero;
		logic                        nzero;
		logic [LANES-1:0]            neg;
		logic [LANES-1:0][Q_W-1:0]   q;
		cbt_vec3_t                   t;
	} cbt_dv_t;

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	// Q50 to Q14, round half away from zero, saturate to 24 bits
	function automatic logic [23:0] to_out(input logic signed [63:0] v);
		logic        neg;
		logic [63:0] m;
		logic [27:0] q;
		logic [63:0] sum;
		neg = v[63];
		m   = neg ? 64'(-v) : 64'(v);
		sum = m + 64'h8_0000_0000;
		q   = sum[63:36];
		if (neg) begin
			return (q > 28'd8388608) ? 24'h800000 : 24'(-q);
		end else begin
			return (q > 28'd8388607) ? 24'h7FFFFF : q[23:0];
		end
	endfunction

endpackage

// File: rtl/core/cbt_sqrt_cell.sv
// One digit stage of the pipelined integer square root.
module cbt_sqrt_cell #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [cbt_pkg::RAD_W-1:0]  rad_i,
	input  logic [cbt_pkg::REM_W-1:0]  rem_i,
	input  logic [cbt_pkg::ROOT_W-1:0] root_i,
	input  logic [SIDE_W-1:0]          side_i,
	output logic [cbt_pkg::RAD_W-1:0]  rad_o,
	output logic [cbt_pkg::REM_W-1:0]  rem_o,
	output logic [cbt_pkg::ROOT_W-1:0] root_o,
	output logic [SIDE_W-1:0]          side_o
);
	import cbt_pkg::*;

	logic [RAD_W-1:0]  rad_s1;
	logic [REM_W-1:0]  rem_s1;
	logic [ROOT_W-1:0] root_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [REM_W-1:0]  rem2;
	logic [REM_W-1:0]  trial;
	logic              ge;

	assign rem2  = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
	assign trial = REM_W'({root_i, 2'b01});
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1  <= {rad_i[RAD_W-3:0], 2'b00};
			rem_s1  <= ge ? rem2 - trial : rem2;
			root_s1 <= {root_i[ROOT_W-2:0], ge};
			side_s1 <= side_i;
		end
	end

	assign rad_o  = rad_s1;
	assign rem_o  = rem_s1;
	assign root_o = root_s1;
	assign side_o = side_s1;

endmodule

// File: rtl/core/cbt_div_cell.sv
// One quotient bit of the pipelined restoring divider.
module cbt_div_cell #(
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [cbt_pkg::DV_W-1:0] rem_i,
	input  logic [cbt_pkg::DV_W-1:0] d_i,
	input  logic [cbt_pkg::Q_W-1:0]  q_i,
	input  logic [SIDE_W-1:0]        side_i,
	output logic [cbt_pkg::DV_W-1:0] rem_o,
	output logic [cbt_pkg::DV_W-1:0] d_o,
	output logic [cbt_pkg::Q_W-1:0]  q_o,
	output logic [SIDE_W-1:0]        side_o
);
	import cbt_pkg::*;

	logic [DV_W-1:0]   rem_s1;
	logic [DV_W-1:0]   d_s1;
	logic [Q_W-1:0]    q_s1;
	logic [SIDE_W-1:0] side_s1;
	logic              ge;

	assign ge = rem_i >= d_i;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1  <= ge ? rem_i - d_i : rem_i;
			d_s1    <= d_i >> 1;
			q_s1    <= {q_i[Q_W-2:0], ge};
			side_s1 <= side_i;
		end
	end

	assign rem_o  = rem_s1;
	assign d_o    = d_s1;
	assign q_o    = q_s1;
	assign side_o = side_s1;

endmodule

// File: rtl/core/cbt_mat.sv
// Rodrigues matrix, column scaling, rounding and the output register.
module cbt_mat (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  cbt_pkg::cbt_dv_t            dv,
	input  logic [2:0][15:0]            scale,
	output logic                        out_vld,
	output logic [2:0][2:0][23:0]       m_out,
	output cbt_pkg::cbt_vec3_t          t_out
);
	import cbt_pkg::*;

	logic                        v_s1, v_s2, v_s3, v_s4, v_s5;
	cbt_vec3_t                   t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [15:0]          c_s1, s_s1;
	logic signed [2:0][15:0]     u_s1;
	logic signed [15:0]          val [LANES];
	logic signed [2:0][2:0][31:0] uu_s2;
	logic signed [2:0][31:0]     su_s2;
	logic signed [16:0]          omc_s2;
	logic signed [15:0]          c_s2;
	logic signed [2:0][2:0][48:0] e_s3;
	logic signed [2:0][2:0][63:0] p_s4;
	logic [2:0][2:0][23:0]       m_s5;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [Q_W-1:0] qc;
			qc = (dv.q[l] > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : dv.q[l];
			val[l] = dv.neg[l] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dv.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= dv.rzero ? 16'(ONE_Q14) : val[LN_COS];
			s_s1 <= dv.rzero ? 16'sd0 : val[LN_SIN];
			for (int k = 0; k < 3; k++) begin
				u_s1[k] <= dv.nzero ? 16'sd0 : val[LN_UX + k];
			end
			t_s1 <= dv.t;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					uu_s2[i][j] <= $signed(u_s1[i]) * $signed(u_s1[j]);
				end
				su_s2[i] <= s_s1 * $signed(u_s1[i]);
			end
			omc_s2 <= 17'(ONE_Q14) - 17'(c_s1);
			c_s2   <= c_s1;
			t_s2   <= t_s1;
			t_s3   <= t_s2;
			t_s4   <= t_s3;
			t_s5   <= t_s4;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			logic signed [48:0] base;
			assign base = 49'($signed(uu_s2[i][j])) * 49'(omc_s2);
			if (i == j) begin : g_diag
				always_ff @(posedge clk) begin
					if (adv) begin
						e_s3[i][j] <= base + (49'(c_s2) <<< 28);
					end
				end
			end else begin : g_off
				localparam int K = 3 - i - j;
				if (j == (i + 1) % 3) begin : g_minus
					always_ff @(posedge clk) begin
						if (adv) begin
							e_s3[i][j] <= base - (49'($signed(su_s2[K])) <<< 14);
						end
					end
				end else begin : g_plus
					always_ff @(posedge clk) begin
						if (adv) begin
							e_s3[i][j] <= base + (49'($signed(su_s2[K])) <<< 14);
						end
					end
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					p_s4[i][j] <= 64'($signed(e_s3[i][j]) * 66'($signed({1'b0, scale[j]})));
					m_s5[i][j] <= to_out(p_s4[i][j]);
				end
			end
		end
	end

	assign out_vld = v_s5;
	assign m_out   = m_s5;
	assign t_out   = t_s5;

endmodule

// File: rtl/core/cylindrical_billboard_transform.sv
// Cylindrical billboard transform: top level with square-root and divider cell rows.
// Stages from input accept to result: 1 prep, 30 root cells, 1 divider prep,
// 15 divider cells, 5 matrix stages. Throughput: one item per cycle while no result sits stalled.
// The whole pipeline moves together; it holds only while a result sits stalled.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register reset values.
module cylindrical_billboard_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] view_xz,
	input  logic signed [15:0] view_zz,
	input  logic signed [31:0] world_tx,
	input  logic signed [31:0] world_ty,
	input  logic signed [31:0] world_tz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] m_xx,
	output logic signed [23:0] m_xy,
	output logic signed [23:0] m_xz,
	output logic signed [23:0] m_yx,
	output logic signed [23:0] m_yy,
	output logic signed [23:0] m_yz,
	output logic signed [23:0] m_zx,
	output logic signed [23:0] m_zy,
	output logic signed [23:0] m_zz,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import cbt_pkg::*;

	localparam int RSIDE_W = 16 + 16 + 2 + 96;
	localparam int NSIDE_W = 3 * 16 + 3;
	localparam int TAIL_W  = 2 + 96;

	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
	logic [2:0][15:0]   scale_q;

	logic adv;
	logic out_vld;

	logic                v_s1;
	logic [31:0]         r2_s1, n2_s1;
	logic [RSIDE_W-1:0]  rside_s1;
	logic [NSIDE_W-1:0]  nside_s1;
	logic signed [31:0]  sq_xz, sq_zz, sq_ax, sq_ay, sq_az;

	logic                vld_q [CH_N];

	logic [RAD_W-1:0]   r_rad  [SQ_N+1];
	logic [REM_W-1:0]   r_rem  [SQ_N+1];
	logic [ROOT_W-1:0]  r_root [SQ_N+1];
	logic [RSIDE_W-1:0] r_side [SQ_N+1];
	logic [RAD_W-1:0]   n_rad  [SQ_N+1];
	logic [REM_W-1:0]   n_rem  [SQ_N+1];
	logic [ROOT_W-1:0]  n_root [SQ_N+1];
	logic [NSIDE_W-1:0] n_side [SQ_N+1];

	logic [15:0]        mxz, mzz;
	logic               negc, negs;
	cbt_vec3_t          t_r;
	logic [2:0][15:0]   max3;
	logic [2:0]         nega;

	logic [LANES-1:0][DV_W-1:0] dn_s2, dd_s2;
	logic [LANES-1:0]           dneg_s2;
	logic [TAIL_W-1:0]          tail_s2;
	logic [LANES-1:0][15:0]     lane_m;
	logic [LANES-1:0][ROOT_W-1:0] lane_root;

	logic [DV_W-1:0]   d_rem  [LANES][DV_N+1];
	logic [DV_W-1:0]   d_d    [LANES][DV_N+1];
	logic [Q_W-1:0]    d_q    [LANES][DV_N+1];
	logic              d_neg  [LANES][DV_N+1];
	logic [TAIL_W-1:0] tail_q [DV_N];

	cbt_dv_t               dv;
	logic [2:0][2:0][23:0] m_out;
	cbt_vec3_t             t_out;

	assign adv       = !out_vld || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= 16'sd0;
			axis_y_q <= 16'sd16384;
			axis_z_q <= 16'sd0;
			scale_q  <= {3{16'd256}};
		end else if (cfg_valid && cfg_ready) begin
			case (cbt_cfg_idx_t'(cfg_index))
				CFG_AXIS_X:  axis_x_q   <= cfg_data;
				CFG_AXIS_Y:  axis_y_q   <= cfg_data;
				CFG_AXIS_Z:  axis_z_q   <= cfg_data;
				CFG_SCALE_X: scale_q[0] <= cfg_data;
				CFG_SCALE_Y: scale_q[1] <= cfg_data;
				CFG_SCALE_Z: scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// prep: squared lengths, magnitudes and signs
	assign sq_xz = view_xz * view_xz;
	assign sq_zz = view_zz * view_zz;
	assign sq_ax = axis_x_q * axis_x_q;
	assign sq_ay = axis_y_q * axis_y_q;
	assign sq_az = axis_z_q * axis_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < CH_N; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1     <= in_valid;
			vld_q[0] <= v_s1;
			for (int k = 1; k < CH_N; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s1    <= 32'(sq_xz) + 32'(sq_zz);
			n2_s1    <= 32'(sq_ax) + 32'(sq_ay) + 32'(sq_az);
			rside_s1 <= {abs16(view_xz), abs16(view_zz), view_zz[15],
				(view_xz != 16'sd0) && !view_xz[15], world_tz, world_ty, world_tx};
			nside_s1 <= {abs16(axis_z_q), abs16(axis_y_q), abs16(axis_x_q),
				axis_z_q[15], axis_y_q[15], axis_x_q[15]};
		end
	end

	assign r_rad[0]  = {r2_s1, 28'd0};
	assign r_rem[0]  = '0;
	assign r_root[0] = '0;
	assign r_side[0] = rside_s1;
	assign n_rad[0]  = {n2_s1, 28'd0};
	assign n_rem[0]  = '0;
	assign n_root[0] = '0;
	assign n_side[0] = nside_s1;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		cbt_sqrt_cell #(.SIDE_W(RSIDE_W)) u_r (
			.clk(clk), .adv(adv),
			.rad_i(r_rad[k]), .rem_i(r_rem[k]), .root_i(r_root[k]), .side_i(r_side[k]),
			.rad_o(r_rad[k+1]), .rem_o(r_rem[k+1]), .root_o(r_root[k+1]),
			.side_o(r_side[k+1])
		);
		cbt_sqrt_cell #(.SIDE_W(NSIDE_W)) u_n (
			.clk(clk), .adv(adv),
			.rad_i(n_rad[k]), .rem_i(n_rem[k]), .root_i(n_root[k]), .side_i(n_side[k]),
			.rad_o(n_rad[k+1]), .rem_o(n_rem[k+1]), .root_o(n_root[k+1]),
			.side_o(n_side[k+1])
		);
	end

	assign {mxz, mzz, negc, negs, t_r} = r_side[SQ_N];
	assign {max3, nega}                = n_side[SQ_N];

	assign lane_m[LN_COS]    = mzz;
	assign lane_m[LN_SIN]    = mxz;
	assign lane_root[LN_COS] = r_root[SQ_N];
	assign lane_root[LN_SIN] = r_root[SQ_N];
	for (genvar k = 0; k < 3; k++) begin : g_ax
		assign lane_m[LN_UX + k]    = max3[k];
		assign lane_root[LN_UX + k] = n_root[SQ_N];
	end

	// divider prep: N = 2*m*2^28 + root, divisor 2*root aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				dn_s2[l] <= DV_W'({lane_m[l], 29'd0}) + DV_W'(lane_root[l]);
				dd_s2[l] <= DV_W'({lane_root[l], 15'd0});
			end
			dneg_s2 <= {nega, negs, negc};
			tail_s2 <= {r_root[SQ_N] == '0, n_root[SQ_N] == '0, t_r};
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign d_rem[l][0] = dn_s2[l];
		assign d_d[l][0]   = dd_s2[l];
		assign d_q[l][0]   = '0;
		assign d_neg[l][0] = dneg_s2[l];
		for (genvar k = 0; k < DV_N; k++) begin : g_dv
			cbt_div_cell #(.SIDE_W(1)) u_d (
				.clk(clk), .adv(adv),
				.rem_i(d_rem[l][k]), .d_i(d_d[l][k]), .q_i(d_q[l][k]),
				.side_i(d_neg[l][k]),
				.rem_o(d_rem[l][k+1]), .d_o(d_d[l][k+1]), .q_o(d_q[l][k+1]),
				.side_o(d_neg[l][k+1])
			);
		end
		assign dv.neg[l] = d_neg[l][DV_N];
		assign dv.q[l]   = d_q[l][DV_N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tail_q[0] <= tail_s2;
			for (int k = 1; k < DV_N; k++) begin
				tail_q[k] <= tail_q[k-1];
			end
		end
	end

	assign dv.valid = vld_q[CH_N-1];
	assign {dv.rzero, dv.nzero, dv.t} = tail_q[DV_N-1];

	cbt_mat u_mat (
		.clk(clk), .arst_n(arst_n), .adv(adv), .dv(dv), .scale(scale_q),
		.out_vld(out_vld), .m_out(m_out), .t_out(t_out)
	);

	assign out_valid = out_vld;
	assign m_xx  = m_out[0][0];
	assign m_xy  = m_out[0][1];
	assign m_xz  = m_out[0][2];
	assign m_yx  = m_out[1][0];
	assign m_yy  = m_out[1][1];
	assign m_yz  = m_out[1][2];
	assign m_zx  = m_out[2][0];
	assign m_zy  = m_out[2][1];
	assign m_zz  = m_out[2][2];
	assign pos_x = t_out[0];
	assign pos_y = t_out[1];
	assign pos_z = t_out[2];

endmodule

// File: rtl/core/cbt_chk.sv
// Port-level checks for the cylindrical billboard transform, bound to the top level.
module cbt_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               cfg_ready,
	input logic signed [23:0] m_xx,
	input logic signed [31:0] pos_x
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(m_xx) && $stable(pos_x))
		else $error("stalled item changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not from a held output item");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
		else $error("output item appeared while pipeline held");

	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind cylindrical_billboard_transform cbt_chk u_cbt_chk (.*);
